// File: hdl/i2c_register_access_master_top_defines.svh
// ----------------------------------------------------------------------------
// Register-access I2C master: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define I2C_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define I2C_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/i2c_ram_pkg.sv
// ----------------------------------------------------------------------------
// Register-access I2C master: package
// Word types, widths and constants shared by the block's modules.
// ----------------------------------------------------------------------------
package i2c_ram_pkg;

  localparam int unsigned RegAddrW          = 16;
  localparam int unsigned CountW            = 9;
  localparam int unsigned DevAddrW          = 7;
  localparam int unsigned MaxBytes          = 256;
  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [DevAddrW-1:0] DevAddrReset = 7'd20;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [RegAddrW-1:0] register_address;
    logic [CountW-1:0]   byte_count;
    logic [7:0]          write_data;
    logic                sda_sample;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       need_write_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       nack_seen;
    logic       done_res;
  } out_word_t;

  // Classified word as it sits in the queue between front and back.
  typedef struct packed {
    logic                start;
    logic                is_read;
    logic [RegAddrW-1:0] register_address;
    logic [CountW-1:0]   byte_count;
    logic [7:0]          write_data;
    logic                sda_sample;
  } front_word_t;

endpackage

// File: hdl/i2c_ram_front.sv
// ----------------------------------------------------------------------------
// Register-access I2C master: front end
// Accepts input words, decodes the opcode and bounds the byte count.
// ----------------------------------------------------------------------------
module i2c_ram_front
  import i2c_ram_pkg::*;
(
  input  logic        in_valid_i,
  input  in_word_t    in_word_i,
  output logic        in_stall_o,
  input  logic        q_full_i,
  output logic        push_o,
  output front_word_t push_word_o
);

  logic [CountW-1:0] count;

  always_comb begin
    count = in_word_i.byte_count;
    if (count == '0) begin
      count = CountW'(1);
    end else if (32'(count) > MaxBytes) begin
      count = CountW'(MaxBytes);
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Opcode three counts as a plain tick.
  assign push_word_o.start            = (in_word_i.opcode == OP_WRITE) ||
                                        (in_word_i.opcode == OP_READ);
  assign push_word_o.is_read          = (in_word_i.opcode == OP_READ);
  assign push_word_o.register_address = in_word_i.register_address;
  assign push_word_o.byte_count       = count;
  assign push_word_o.write_data       = in_word_i.write_data;
  assign push_word_o.sda_sample       = in_word_i.sda_sample;

endmodule

// File: hdl/i2c_ram_queue.sv
// ----------------------------------------------------------------------------
// Register-access I2C master: word queue
// Small FIFO that decouples the front end from the bus sequencer.
// ----------------------------------------------------------------------------
module i2c_ram_queue
  import i2c_ram_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  front_word_t push_word_i,
  input  logic        pop_i,
  output front_word_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  front_word_t         mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// File: hdl/i2c_ram_back.sv
// ----------------------------------------------------------------------------
// Register-access I2C master: bus sequencer
// Steps the transaction state once per queued tick and registers the result.
// ----------------------------------------------------------------------------
module i2c_ram_back
  import i2c_ram_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [DevAddrW-1:0] cfg_wdata_i,
  input  front_word_t         head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o
);

  typedef enum logic [14:0] {
    ST_IDLE      = 15'b000000000000001,
    ST_BIT_LOW   = 15'b000000000000010,
    ST_BIT_HIGH  = 15'b000000000000100,
    ST_ACK_LOW   = 15'b000000000001000,
    ST_ACK_HIGH  = 15'b000000000010000,
    ST_RS_LOW    = 15'b000000000100000,
    ST_RS_HIGH   = 15'b000000001000000,
    ST_RS_FALL   = 15'b000000010000000,
    ST_RX_LOW    = 15'b000000100000000,
    ST_RX_HIGH   = 15'b000001000000000,
    ST_MACK_LOW  = 15'b000010000000000,
    ST_MACK_HIGH = 15'b000100000000000,
    ST_STOP_LOW  = 15'b001000000000000,
    ST_STOP_HIGH = 15'b010000000000000,
    ST_STOP_RISE = 15'b100000000000000
  } state_e;

  typedef enum logic [2:0] {
    KIND_ADDR_W = 3'd0,
    KIND_REG_HI = 3'd1,
    KIND_REG_LO = 3'd2,
    KIND_DATA   = 3'd3,
    KIND_ADDR_R = 3'd4
  } kind_e;

  state_e              state_q, state_d;
  kind_e               kind_q, kind_d;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic [CountW-1:0]   left_q, left_d;
  logic [RegAddrW-1:0] reg_addr_q, reg_addr_d;
  logic                is_read_q, is_read_d;
  logic                nack_q, nack_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic [DevAddrW-1:0] dev_addr_q;
  logic                out_valid_q;
  out_word_t           out_word_q;

  logic                need, rvalid, done;
  logic [7:0]          rdata;
  logic [7:0]          cur_byte;
  logic [7:0]          rx_byte;
  logic [CountW-1:0]   left_dec;
  out_word_t           result;

  assign pop_o    = !empty_i && (!out_valid_q || !out_stall_i);
  assign left_dec = (left_q != '0) ? left_q - CountW'(1) : left_q;
  assign cur_byte = (kind_q == KIND_DATA && bit_q == '0) ? head_i.write_data : shift_q;
  assign rx_byte  = {shift_q[6:0], head_i.sda_sample};

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    left_d     = left_q;
    reg_addr_d = reg_addr_q;
    is_read_d  = is_read_q;
    nack_d     = nack_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    need       = 1'b0;
    rvalid     = 1'b0;
    rdata      = '0;
    done       = 1'b0;

    unique case (state_q)
      ST_BIT_LOW: begin
        shift_d = cur_byte;
        scl_d   = 1'b0;
        sda_d   = cur_byte[7];
        state_d = ST_BIT_HIGH;
      end
      ST_BIT_HIGH: begin
        scl_d   = 1'b1;
        sda_d   = shift_q[7];
        shift_d = {shift_q[6:0], 1'b0};
        bit_d   = bit_q + 3'd1;
        state_d = (bit_q == 3'd7) ? ST_ACK_LOW : ST_BIT_LOW;
      end
      ST_ACK_LOW: begin
        scl_d   = 1'b0;
        sda_d   = 1'b1;
        state_d = ST_ACK_HIGH;
      end
      ST_ACK_HIGH: begin
        scl_d = 1'b1;
        sda_d = 1'b1;
        if (head_i.sda_sample) begin
          nack_d = 1'b1;
        end
        bit_d = '0;
        case (kind_q)
          KIND_ADDR_W: begin
            kind_d  = KIND_REG_HI;
            shift_d = reg_addr_q[15:8];
            state_d = ST_BIT_LOW;
          end
          KIND_REG_HI: begin
            kind_d  = KIND_REG_LO;
            shift_d = reg_addr_q[7:0];
            state_d = ST_BIT_LOW;
          end
          KIND_REG_LO: begin
            if (is_read_q) begin
              state_d = ST_RS_LOW;
            end else begin
              kind_d  = KIND_DATA;
              shift_d = '0;
              need    = 1'b1;
              state_d = ST_BIT_LOW;
            end
          end
          KIND_DATA: begin
            left_d = left_dec;
            if (left_dec != '0) begin
              shift_d = '0;
              need    = 1'b1;
              state_d = ST_BIT_LOW;
            end else begin
              state_d = ST_STOP_LOW;
            end
          end
          default: begin
            shift_d = '0;
            state_d = ST_RX_LOW;
          end
        endcase
      end
      ST_RS_LOW: begin
        scl_d   = 1'b0;
        sda_d   = 1'b1;
        state_d = ST_RS_HIGH;
      end
      ST_RS_HIGH: begin
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        state_d = ST_RS_FALL;
      end
      ST_RS_FALL: begin
        scl_d   = 1'b1;
        sda_d   = 1'b0;
        kind_d  = KIND_ADDR_R;
        bit_d   = '0;
        shift_d = {dev_addr_q, 1'b1};
        state_d = ST_BIT_LOW;
      end
      ST_RX_LOW: begin
        scl_d   = 1'b0;
        sda_d   = 1'b1;
        state_d = ST_RX_HIGH;
      end
      ST_RX_HIGH: begin
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        shift_d = rx_byte;
        bit_d   = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          rvalid  = 1'b1;
          rdata   = rx_byte;
          state_d = ST_MACK_LOW;
        end else begin
          state_d = ST_RX_LOW;
        end
      end
      ST_MACK_LOW: begin
        scl_d   = 1'b0;
        sda_d   = (left_q <= CountW'(1));
        state_d = ST_MACK_HIGH;
      end
      ST_MACK_HIGH: begin
        scl_d  = 1'b1;
        sda_d  = (left_q <= CountW'(1));
        left_d = left_dec;
        if (left_dec != '0) begin
          bit_d   = '0;
          shift_d = '0;
          state_d = ST_RX_LOW;
        end else begin
          state_d = ST_STOP_LOW;
        end
      end
      ST_STOP_LOW: begin
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        state_d = ST_STOP_HIGH;
      end
      ST_STOP_HIGH: begin
        scl_d   = 1'b1;
        sda_d   = 1'b0;
        state_d = ST_STOP_RISE;
      end
      ST_STOP_RISE: begin
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        done    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        // Idle: lines released; a start opcode issues START and loads the address byte.
        state_d = ST_IDLE;
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        if (head_i.start) begin
          reg_addr_d = head_i.register_address;
          left_d     = head_i.byte_count;
          is_read_d  = head_i.is_read;
          nack_d     = 1'b0;
          sda_d      = 1'b0;
          kind_d     = KIND_ADDR_W;
          bit_d      = '0;
          shift_d    = {dev_addr_q, 1'b0};
          state_d    = ST_BIT_LOW;
        end
      end
    endcase

    result.scl_level       = scl_d;
    result.sda_level       = sda_d;
    result.busy_res        = (state_d != ST_IDLE) || done;
    result.need_write_byte = need;
    result.read_valid      = rvalid;
    result.read_data       = rdata;
    result.nack_seen       = nack_d;
    result.done_res        = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_q     <= KIND_ADDR_W;
      bit_q      <= '0;
      shift_q    <= '0;
      left_q     <= '0;
      reg_addr_q <= '0;
      is_read_q  <= 1'b0;
      nack_q     <= 1'b0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
    end else if (pop_o) begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      left_q     <= left_d;
      reg_addr_q <= reg_addr_d;
      is_read_q  <= is_read_d;
      nack_q     <= nack_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: hdl/i2c_register_access_master_top.sv
// Register-access I2C master, one bus phase per input word.
// The input channel (in_valid_i, in_stall_o, in_word_i) carries one phase tick
// per word: an opcode, the register address, a byte count, the next write byte
// and the sampled SDA level. The output channel (out_valid_o, out_stall_i,
// out_word_o) returns exactly one word per input word with the SCL and SDA
// levels to drive, busy, the write-byte request, received bytes, the sticky
// NACK flag and the end-of-STOP strobe.
// The device address register is written through cfg_we_i / cfg_wdata_i; the
// user must do so only while the block is idle (not enforced); it resets to 20.
// An accepted word is written into the queue; the sequencer then pops it and
// registers its result in the output word register, which holds it while stalled.
// Throughput is one word per cycle while out_stall_i is low; the figure is set
// by the sequencer, which updates its state once per word.
// A stall on the output holds the registered result word and lets the queue
// (two entries by default) fill; once full, in_stall_o rises until a word drains.
// Reset clears the queue, releases both lines and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// Register-access I2C master: top level
// Front end, word queue and bus sequencer with a registered output word.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top
  import i2c_ram_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [DevAddrW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o
);

  // Queue handshake between the front end and the sequencer.
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  front_word_t push_word;
  front_word_t head_word;

  // Front end decodes the opcode and bounds the byte count to the legal range.
  i2c_ram_front u_front (
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_word_o (push_word)
  );

  // The queue lets the front end keep accepting while the output is stalled.
  i2c_ram_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .head_o      (head_word),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // The sequencer consumes one queued word per cycle whenever the output
  // register is free or being emptied.
  i2c_ram_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head_word),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: hdl/i2c_ram_checker.sv
// ----------------------------------------------------------------------------
// Register-access I2C master: port checker
// Checks the handshakes and the output words of the top level over time.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_top_defines.svh"

module i2c_ram_checker
  import i2c_ram_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input in_word_t            in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input out_word_t           out_word_o
);

  `I2C_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o,
    in_valid_i && $stable(in_word_i), "stalled input word changed")

  `I2C_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_word_o), "stalled output word changed")

  `I2C_ASSERT_IMP(a_read_on_scl_high, clk_i, rst_ni, out_valid_o && out_word_o.read_valid,
    out_word_o.scl_level && out_word_o.busy_res, "read byte outside a busy SCL-high phase")

  `I2C_ASSERT_IMP(a_done_released, clk_i, rst_ni, out_valid_o && out_word_o.done_res,
    out_word_o.scl_level && out_word_o.sda_level && out_word_o.busy_res,
    "STOP end with a line held low")

  `I2C_ASSERT_IMP(a_need_on_ack, clk_i, rst_ni, out_valid_o && out_word_o.need_write_byte,
    out_word_o.scl_level && out_word_o.sda_level && !out_word_o.read_valid,
    "write byte requested outside an ACK phase")

endmodule

bind i2c_register_access_master_top i2c_ram_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
